[rtl/mwgs_pkg.sv]
`default_nettype none

package mwgs_pkg;

    localparam int DEF_MAX_ITEMS  = 256;
    localparam int DEF_VALUE_BITS = 30;
    localparam int TOTAL_W        = 38;
    localparam int GAP_LIMIT      = 2;
    localparam int LOOK_BACK      = 3;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2
    } t_chain_op;

    typedef enum logic [1:0] {
        S_LOAD = 2'b01,
        S_RUN  = 2'b10
    } t_state;

endpackage

`default_nettype wire

[rtl/mwgs_in_if.sv]
`default_nettype none

interface mwgs_in_if #(
    parameter int VALUE_BITS = mwgs_pkg::DEF_VALUE_BITS
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] power_value;
    logic                  last_item;

    modport source (output valid, output power_value, output last_item, input ready);
    modport sink   (input valid, input power_value, input last_item, output ready);
endinterface

`default_nettype wire

[rtl/mwgs_out_if.sv]
`default_nettype none

interface mwgs_out_if;
    logic                         valid;
    logic                         ready;
    logic [mwgs_pkg::TOTAL_W-1:0] total_damage;
    logic                         overflow;

    modport source (output valid, output total_damage, output overflow, input ready);
    modport sink   (input valid, input total_damage, input overflow, output ready);
endinterface

`default_nettype wire

[rtl/mwgs_cell.sv]
`default_nettype none

module mwgs_cell #(
    parameter int VALUE_BITS = mwgs_pkg::DEF_VALUE_BITS,
    parameter int CNT_W      = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mwgs_pkg::t_chain_op   i_op,
    input  logic [VALUE_BITS-1:0] i_new_val,
    input  logic                  i_hit,
    input  logic                  i_prev_vld,
    input  logic [VALUE_BITS-1:0] i_prev_val,
    input  logic [CNT_W-1:0]      i_prev_cnt,
    input  logic                  i_prev_gt,
    input  logic                  i_next_vld,
    input  logic [VALUE_BITS-1:0] i_next_val,
    input  logic [CNT_W-1:0]      i_next_cnt,
    output logic                  o_vld,
    output logic [VALUE_BITS-1:0] o_val,
    output logic [CNT_W-1:0]      o_cnt,
    output logic                  o_gt,
    output logic                  o_eq
);
    import mwgs_pkg::*;

    logic                  r_vld, n_vld;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  w_gt, w_eq;

    assign w_eq = r_vld && (r_val == i_new_val);
    assign w_gt = !r_vld || (r_val > i_new_val);

    always_comb begin
        n_vld = r_vld;
        n_val = r_val;
        n_cnt = r_cnt;
        unique case (i_op)
            OP_HOLD: begin
            end
            OP_INSERT: begin
                // an equal value anywhere in the row only bumps its count
                priority if (w_eq) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end else if (w_gt && !i_hit) begin
                    if (i_prev_gt) begin
                        n_vld = i_prev_vld;
                        n_val = i_prev_val;
                        n_cnt = i_prev_cnt;
                    end else begin
                        n_vld = 1'b1;
                        n_val = i_new_val;
                        n_cnt = CNT_W'(1);
                    end
                end
            end
            OP_POP: begin
                n_vld = i_next_vld;
                n_val = i_next_val;
                n_cnt = i_next_cnt;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_cnt <= n_cnt;
    end

    assign o_vld = r_vld;
    assign o_val = r_val;
    assign o_cnt = r_cnt;
    assign o_gt  = w_gt;
    assign o_eq  = w_eq;

endmodule

`default_nettype wire

[rtl/mwgs_dp.sv]
`default_nettype none

module mwgs_dp #(
    parameter int VALUE_BITS = mwgs_pkg::DEF_VALUE_BITS,
    parameter int CNT_W      = 9,
    parameter int SUM_W      = VALUE_BITS + CNT_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_pop,
    input  logic [VALUE_BITS-1:0] i_head_val,
    input  logic [CNT_W-1:0]      i_head_cnt,
    output logic                  o_busy,
    output logic [SUM_W-1:0]      o_best
);
    import mwgs_pkg::*;

    localparam int HC_W = $clog2(LOOK_BACK + 1);

    logic                  r_a_vld;
    logic [VALUE_BITS-1:0] r_a_val;
    logic [SUM_W-1:0]      r_a_wt;
    logic [SUM_W-1:0]      w_prod;

    logic [VALUE_BITS-1:0] r_h_val  [LOOK_BACK];
    logic [SUM_W-1:0]      r_h_best [LOOK_BACK];
    logic [HC_W-1:0]       r_h_cnt;

    logic [VALUE_BITS-1:0] w_diff [LOOK_BACK];
    logic [SUM_W-1:0]      w_cand [LOOK_BACK];
    logic [SUM_W-1:0]      w_take;
    logic [SUM_W-1:0]      w_best;

    assign w_prod = SUM_W'(i_head_val) * SUM_W'(i_head_cnt);

    always_comb begin
        for (int j = 0; j < LOOK_BACK; j++) begin
            w_diff[j] = r_a_val - r_h_val[j];
            w_cand[j] = r_h_best[j] + r_a_wt;
        end
    end

    // nearest earlier value more than the gap below wins
    always_comb begin
        w_take = r_a_wt;
        for (int j = LOOK_BACK - 1; j >= 0; j--) begin
            if ((r_h_cnt > HC_W'(j)) && (w_diff[j] > VALUE_BITS'(GAP_LIMIT))) begin
                w_take = w_cand[j];
            end
        end
        w_best = (w_take > r_h_best[0]) ? w_take : r_h_best[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_h_cnt <= '0;
        end else begin
            r_a_vld <= i_pop;
            if (i_start) begin
                r_h_cnt <= '0;
            end else if (r_a_vld && (r_h_cnt != HC_W'(LOOK_BACK))) begin
                r_h_cnt <= r_h_cnt + HC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_val <= i_head_val;
        r_a_wt  <= w_prod;
        if (i_start) begin
            for (int j = 0; j < LOOK_BACK; j++) begin
                r_h_best[j] <= '0;
            end
        end else if (r_a_vld) begin
            for (int j = LOOK_BACK - 1; j > 0; j--) begin
                r_h_val[j]  <= r_h_val[j-1];
                r_h_best[j] <= r_h_best[j-1];
            end
            r_h_val[0]  <= r_a_val;
            r_h_best[0] <= w_best;
        end
    end

    assign o_busy = r_a_vld;
    assign o_best = r_h_best[0];

endmodule

`default_nettype wire

[rtl/max_weight_gap_selection.sv]
`default_nettype none

// Values stream in at one beat per cycle while input ready is high and are
// insertion-sorted into a row of MAX_ITEMS cells, each holding one distinct
// value and its count; equal values only bump a count. Beats past MAX_ITEMS in
// a batch are dropped and flag overflow. After the beat marked last, input
// ready stays low while the row shifts its contents out, one distinct value a
// cycle, into a two-stage weight/selection unit: the result is registered once
// the row is empty and that unit is idle, and input ready rises again as it is
// registered. A result not yet taken holds the end of the next batch's
// selection pass, and the input with it, until the output register is free.
module max_weight_gap_selection #(
    parameter int MAX_ITEMS  = mwgs_pkg::DEF_MAX_ITEMS,
    parameter int VALUE_BITS = mwgs_pkg::DEF_VALUE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mwgs_in_if.sink    i_item,
    mwgs_out_if.source o_result
);
    import mwgs_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ITEM_W = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W  = VALUE_BITS + CNT_W;

    t_state                r_state, n_state;
    t_chain_op             w_op;
    logic [ITEM_W-1:0]     r_items;
    logic                  r_ovf;
    logic                  r_out_vld;
    logic [TOTAL_W-1:0]    r_out_total;
    logic                  r_out_ovf;

    logic                  w_accept, w_drop, w_done, w_out_free, w_finish;
    logic                  w_dp_busy;
    logic                  w_hit;
    logic [SUM_W-1:0]      w_best;
    logic [SUM_W+TOTAL_W-1:0] w_best_ext;

    logic                  w_vld [MAX_ITEMS];
    logic [VALUE_BITS-1:0] w_val [MAX_ITEMS];
    logic [CNT_W-1:0]      w_cnt [MAX_ITEMS];
    logic                  w_gt  [MAX_ITEMS];
    logic                  w_eq  [MAX_ITEMS];

    assign i_item.ready = (r_state == S_LOAD);
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_drop       = (r_items == ITEM_W'(MAX_ITEMS));
    assign w_done       = (r_state == S_RUN) && !w_vld[0] && !w_dp_busy;
    assign w_out_free   = !r_out_vld || o_result.ready;
    assign w_finish     = w_done && w_out_free;

    always_comb begin
        w_hit = 1'b0;
        for (int k = 0; k < MAX_ITEMS; k++) begin
            w_hit = w_hit | w_eq[k];
        end
    end

    always_comb begin
        w_op = OP_HOLD;
        if (w_accept && !w_drop) begin
            w_op = OP_INSERT;
        end else if ((r_state == S_RUN) && w_vld[0]) begin
            w_op = OP_POP;
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
            logic                  w_p_vld, w_p_gt, w_n_vld;
            logic [VALUE_BITS-1:0] w_p_val, w_n_val;
            logic [CNT_W-1:0]      w_p_cnt, w_n_cnt;

            if (g == 0) begin : g_head
                assign w_p_vld = 1'b0;
                assign w_p_val = '0;
                assign w_p_cnt = '0;
                assign w_p_gt  = 1'b0;
            end else begin : g_body
                assign w_p_vld = w_vld[g-1];
                assign w_p_val = w_val[g-1];
                assign w_p_cnt = w_cnt[g-1];
                assign w_p_gt  = w_gt[g-1];
            end

            if (g == MAX_ITEMS - 1) begin : g_tail
                assign w_n_vld = 1'b0;
                assign w_n_val = '0;
                assign w_n_cnt = '0;
            end else begin : g_mid
                assign w_n_vld = w_vld[g+1];
                assign w_n_val = w_val[g+1];
                assign w_n_cnt = w_cnt[g+1];
            end

            mwgs_cell #(
                .VALUE_BITS (VALUE_BITS),
                .CNT_W      (CNT_W)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_op       (w_op),
                .i_new_val  (i_item.power_value),
                .i_hit      (w_hit),
                .i_prev_vld (w_p_vld),
                .i_prev_val (w_p_val),
                .i_prev_cnt (w_p_cnt),
                .i_prev_gt  (w_p_gt),
                .i_next_vld (w_n_vld),
                .i_next_val (w_n_val),
                .i_next_cnt (w_n_cnt),
                .o_vld      (w_vld[g]),
                .o_val      (w_val[g]),
                .o_cnt      (w_cnt[g]),
                .o_gt       (w_gt[g]),
                .o_eq       (w_eq[g])
            );
        end
    endgenerate

    mwgs_dp #(
        .VALUE_BITS (VALUE_BITS),
        .CNT_W      (CNT_W),
        .SUM_W      (SUM_W)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept && i_item.last_item),
        .i_pop      (w_op == OP_POP),
        .i_head_val (w_val[0]),
        .i_head_cnt (w_cnt[0]),
        .o_busy     (w_dp_busy),
        .o_best     (w_best)
    );

    assign w_best_ext = {{TOTAL_W{1'b0}}, w_best};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: if (w_accept && i_item.last_item) n_state = S_RUN;
            S_RUN:  if (w_finish) n_state = S_LOAD;
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_items   <= '0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_finish) begin
                r_items <= '0;
                r_ovf   <= 1'b0;
            end else if (w_accept) begin
                if (w_drop) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_items <= r_items + ITEM_W'(1);
                end
            end
            if (w_finish) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_total <= w_best_ext[TOTAL_W-1:0];
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_result.valid        = r_out_vld;
    assign o_result.total_damage = r_out_total;
    assign o_result.overflow     = r_out_ovf;

endmodule

`default_nettype wire

[rtl/mwgs_chk.sv]
`default_nettype none

module mwgs_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_in_last,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [mwgs_pkg::TOTAL_W-1:0] i_out_total,
    input logic                         i_out_ovf
);

    a_reset_quiet : assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat right after reset");

    a_last_closes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("input still open after last beat");

    a_result_after_pass : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result raised while input was open");

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_total) && $stable(i_out_ovf))
        else $error("stalled result beat changed");

endmodule

bind max_weight_gap_selection mwgs_chk u_mwgs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_last   (i_item.last_item),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_total (o_result.total_damage),
    .i_out_ovf   (o_result.overflow)
);

`default_nettype wire

[verif/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXI        = mwgs_pkg::DEF_MAX_ITEMS;
    localparam int VB          = mwgs_pkg::DEF_VALUE_BITS;
    localparam int TW          = mwgs_pkg::TOTAL_W;
    localparam int STALL_LIMIT = 4000;
    localparam int RAND_ITEMS  = 120;

    typedef logic [VB-1:0] t_value;

    localparam t_value VMAX = '1;

    class selection_scoreboard;
        typedef struct {
            logic [TW-1:0] total;
            logic          ovf;
        } t_result;

        t_value      vals[MAXI];
        int unsigned cnt[MAXI];
        int unsigned distinct;
        int unsigned taken;
        bit          dropped;
        t_result     pending[$];
        int unsigned errors;

        function new();
            distinct = 0;
            taken    = 0;
            dropped  = 0;
            errors   = 0;
        endfunction

        function void note_beat(t_value v, logic last);
            int unsigned       pos;
            longint unsigned   best[MAXI];
            longint unsigned   weight;
            longint unsigned   take;
            longint unsigned   skip;
            t_result           r;
            pos = 0;
            if (taken < MAXI) begin
                while (pos < distinct && vals[pos] < v) pos++;
                if (pos < distinct && vals[pos] == v) begin
                    cnt[pos]++;
                end else begin
                    for (int k = distinct; k > pos; k--) begin
                        vals[k] = vals[k-1];
                        cnt[k]  = cnt[k-1];
                    end
                    vals[pos] = v;
                    cnt[pos]  = 1;
                    distinct++;
                end
                taken++;
            end else begin
                dropped = 1'b1;
            end
            if (!last) return;
            // pass over the distinct values in ascending order
            for (int i = 0; i < distinct; i++) begin
                weight = longint'(vals[i]) * longint'(cnt[i]);
                take   = weight;
                skip   = (i > 0) ? best[i-1] : 64'd0;
                for (int j = 1; j <= mwgs_pkg::LOOK_BACK; j++) begin
                    if (j > i) break;
                    if (vals[i] - vals[i-j] > mwgs_pkg::GAP_LIMIT) begin
                        take = best[i-j] + weight;
                        break;
                    end
                end
                best[i] = (take > skip) ? take : skip;
            end
            r.total = (distinct == 0) ? '0 : best[distinct-1][TW-1:0];
            r.ovf   = dropped;
            pending.push_back(r);
            distinct = 0;
            taken    = 0;
            dropped  = 1'b0;
        endfunction

        function void check_result(logic [TW-1:0] total, logic ovf);
            t_result want;
            if (pending.size() == 0) begin
                $error("unexpected result: total_damage %0d, overflow %0d", total, ovf);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (total !== want.total) begin
                $error("total_damage mismatch: expected %0d, actual %0d", want.total, total);
                errors++;
            end
            if (ovf !== want.ovf) begin
                $error("overflow mismatch: expected %0d, actual %0d", want.ovf, ovf);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   stall_cycles = 0;

    selection_scoreboard sb = new();

    mwgs_in_if #(.VALUE_BITS(VB)) item_if ();
    mwgs_out_if                   result_if ();

    max_weight_gap_selection i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        result_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && item_if.valid && item_if.ready) begin
            sb.note_beat(item_if.power_value, item_if.last_item);
        end
        if (i_rst_n && result_if.valid && result_if.ready) begin
            sb.check_result(result_if.total_damage, result_if.overflow);
        end
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_beat(input t_value v, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid       <= 1'b1;
        item_if.power_value <= v;
        item_if.last_item   <= last;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
    endtask

    task automatic send_batch(input t_value vals[$]);
        for (int k = 0; k < vals.size(); k++) begin
            send_beat(vals[k], k == vals.size() - 1);
        end
    endtask

    initial begin
        t_value batch[$];
        t_value v;
        t_value base;
        t_value tmp;
        int     rand_items;
        int     len;
        int     kind;
        int     spread;
        int     j;

        i_rst_n               = 1'b0;
        item_if.valid         = 1'b0;
        item_if.power_value   = '0;
        item_if.last_item     = 1'b0;
        result_if.ready       = 1'b0;
        src_idle_pct          = 34;
        sink_idle_pct         = 45;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        batch = '{0};
        send_batch(batch);
        batch = '{VMAX};
        send_batch(batch);
        batch = '{1, 2, 3, 4, 5};
        send_batch(batch);
        batch = '{3, 4, 2, 2, 3, 3, 4};
        send_batch(batch);
        batch = '{13, 11, 10, 12};
        send_batch(batch);
        batch = '{t_value'(VMAX - 2), t_value'(VMAX - 1), VMAX, 0};
        send_batch(batch);
        batch = '{5, 5, 5, 5};
        send_batch(batch);

        // full row of distinct values near the top, shuffled, then two dropped beats
        batch = {};
        v = t_value'(VMAX - 1100 - $urandom_range(0, 1000));
        repeat (MAXI) begin
            batch.push_back(v);
            v = t_value'(v + $urandom_range(1, 4));
        end
        for (int k = MAXI - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = batch[k];
            batch[k] = batch[j];
            batch[j] = tmp;
        end
        batch.push_back(VMAX);
        batch.push_back(VMAX);
        send_batch(batch);

        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            if (rand_items < RAND_ITEMS / 3) begin
                src_idle_pct  = 34;
                sink_idle_pct <= 45;
            end else if (rand_items < 2 * RAND_ITEMS / 3) begin
                src_idle_pct  = 45;
                sink_idle_pct <= 34;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct <= 0;
            end
            len    = $urandom_range(1, 12);
            kind   = $urandom_range(0, 9);
            spread = $urandom_range(2, 40);
            base   = t_value'($urandom_range(0, VMAX - 64));
            if ($urandom_range(0, 7) == 0) base = 0;
            if ($urandom_range(0, 7) == 0) base = t_value'(VMAX - spread);
            batch = {};
            repeat (len) begin
                case (kind)
                    0: begin
                        v = t_value'($urandom);
                    end
                    1: begin
                        v = ($urandom_range(0, 1) != 0) ? t_value'($urandom_range(0, 3))
                                                        : t_value'(VMAX - $urandom_range(0, 3));
                    end
                    default: begin
                        v = t_value'(base + $urandom_range(0, spread));
                    end
                endcase
                batch.push_back(v);
            end
            send_batch(batch);
            rand_items += len;
        end
        item_if.valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (MAXI + 8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

[max_weight_gap_selection.f]
rtl/mwgs_pkg.sv
rtl/mwgs_in_if.sv
rtl/mwgs_out_if.sv
rtl/mwgs_cell.sv
rtl/mwgs_dp.sv
rtl/max_weight_gap_selection.sv
rtl/mwgs_chk.sv
verif/tb_top.sv
